### sv/assert_macros.svh
// Assertion macros shared by the receiver RTL.
// Depends on nothing; active unless SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("receiver assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("receiver assertion failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/htpr_pkg.sv
// Shared types and constants for the hex and text packet receiver.
// Depends on nothing.
package htpr_pkg;

    localparam int HEX_PAYLOAD_BYTES_DEF = 4;
    localparam int TEXT_DEPTH_DEF        = 128;

    localparam logic [7:0] HEX_HEADER_RST  = 8'hFF;
    localparam logic [7:0] HEX_TRAILER_RST = 8'hFE;

    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_HEADER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEX_TRAILER = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_STATUS = 2'd1,
        KIND_LAST   = 2'd2,
        KIND_TEXT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_SINGLE = 2'd1,
        ST_HEX    = 2'd2,
        ST_TEXT   = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  data_byte;
        logic        use_mem;
        logic [31:0] hex_payload;
        logic [6:0]  text_length;
    } t_result;

endpackage

### sv/htpr_in_if.sv
// Input channel: received byte or host access, with valid/ready.
// Depends on nothing.
interface htpr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [6:0] read_index;

    modport source(output valid, kind, rx_byte, read_index, input ready);
    modport sink(input valid, kind, rx_byte, read_index, output ready);
endinterface

### sv/htpr_out_if.sv
// Result channel of the receiver, with valid/ready.
// Depends on nothing.
interface htpr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [31:0] hex_payload;
    logic [6:0]  text_length;

    modport source(output valid, status, data_byte, hex_payload, text_length, input ready);
    modport sink(input valid, status, data_byte, hex_payload, text_length, output ready);
endinterface

### sv/htpr_text_mem.sv
// Text character store: one write port, one registered read port.
// Depends on nothing.
module htpr_text_mem #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### sv/htpr_parse.sv
// Framing state machine, configuration registers and hex payload store.
// Depends on htpr_pkg and assert_macros.svh; drives the text store ports.
`include "assert_macros.svh"
module htpr_parse #(
    parameter int HEX_PAYLOAD_BYTES = htpr_pkg::HEX_PAYLOAD_BYTES_DEF,
    parameter int TEXT_DEPTH        = htpr_pkg::TEXT_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [htpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_wdata,
    input  logic                             i_accept,
    input  logic [1:0]                       i_kind,
    input  logic [7:0]                       i_rx_byte,
    input  logic [6:0]                       i_read_index,
    output htpr_pkg::t_result                o_res,
    output logic                             o_mem_we,
    output logic [$clog2(TEXT_DEPTH)-1:0]    o_mem_waddr,
    output logic [7:0]                       o_mem_wdata,
    output logic                             o_mem_re,
    output logic [$clog2(TEXT_DEPTH)-1:0]    o_mem_raddr
);
    import htpr_pkg::*;

    localparam int N        = HEX_PAYLOAD_BYTES;
    localparam int AW       = $clog2(TEXT_DEPTH);
    localparam int TEXT_CAP = (TEXT_DEPTH - 1 < 127) ? TEXT_DEPTH - 1 : 127;
    localparam int TPW      = $clog2(TEXT_CAP + 1);
    localparam int HPW      = $clog2(N + 1);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_TAIL = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        M_SINGLE    = 3'd1,
        M_HEX_DONE  = 3'd2,
        M_TEXT_DONE = 3'd3,
        M_HEX_RX    = 3'd4,
        M_TEXT_RX   = 3'd5
    } t_mode;

    t_phase           r_phase, n_phase;
    t_mode            r_mode, n_mode;
    logic             r_pending, n_pending;
    logic [7:0]       r_last, n_last;
    logic [HPW-1:0]   r_hex_pos, n_hex_pos;
    logic [7:0]       r_hex_store [N];
    logic [7:0]       n_hex_store [N];
    logic [TPW-1:0]   r_text_pos, n_text_pos;
    logic [7:0]       r_hdr, r_trl;
    logic [31:0]      payload;
    t_status          status;
    logic [7:0]       data_byte;
    logic             use_mem;

    always_comb begin
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_pending   = r_pending;
        n_last      = r_last;
        n_hex_pos   = r_hex_pos;
        n_hex_store = r_hex_store;
        n_text_pos  = r_text_pos;
        status      = ST_NONE;
        data_byte   = 8'd0;
        use_mem     = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        if (i_accept) begin
            unique case (t_kind'(i_kind))
                KIND_BYTE: begin
                    n_last = i_rx_byte;
                    unique case (r_phase)
                        PH_BODY: begin
                            if (r_mode == M_HEX_RX) begin
                                for (int i = 0; i < N; i++) begin
                                    if (r_hex_pos == HPW'(i)) begin
                                        n_hex_store[i] = i_rx_byte;
                                    end
                                end
                                n_hex_pos = r_hex_pos + HPW'(1);
                                if (n_hex_pos >= HPW'(N)) begin
                                    n_phase = PH_TAIL;
                                end
                            end else if (r_mode == M_TEXT_RX) begin
                                if (i_rx_byte == CH_CR) begin
                                    n_phase = PH_TAIL;
                                end else if (r_text_pos < TPW'(TEXT_CAP)) begin
                                    o_mem_we   = 1'b1;
                                    n_text_pos = r_text_pos + TPW'(1);
                                end
                            end
                        end
                        PH_TAIL: begin
                            if (r_mode == M_HEX_RX && i_rx_byte == r_trl) begin
                                n_phase   = PH_IDLE;
                                n_pending = 1'b1;
                                n_mode    = M_HEX_DONE;
                                status    = ST_HEX;
                            end else if (r_mode == M_TEXT_RX && i_rx_byte == CH_LF) begin
                                n_phase   = PH_IDLE;
                                n_pending = 1'b1;
                                n_mode    = M_TEXT_DONE;
                                status    = ST_TEXT;
                            end
                        end
                        default: begin
                            if (i_rx_byte == r_hdr) begin
                                n_phase   = PH_BODY;
                                n_hex_pos = '0;
                                n_mode    = M_HEX_RX;
                            end else if (i_rx_byte == CH_AT && !r_pending) begin
                                n_phase    = PH_BODY;
                                n_text_pos = '0;
                                n_mode     = M_TEXT_RX;
                            end else begin
                                n_phase   = PH_IDLE;
                                n_pending = 1'b1;
                                n_mode    = M_SINGLE;
                                status    = ST_SINGLE;
                            end
                        end
                    endcase
                end
                KIND_STATUS: begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        if (r_mode == M_SINGLE || r_mode == M_HEX_DONE ||
                            r_mode == M_TEXT_DONE) begin
                            status = t_status'(r_mode[1:0]);
                        end
                    end
                end
                KIND_LAST: begin
                    data_byte = r_last;
                    n_last    = 8'd0;
                end
                KIND_TEXT: begin
                    if (i_read_index < 7'(r_text_pos)) begin
                        o_mem_re = 1'b1;
                        use_mem  = 1'b1;
                    end
                end
            endcase
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_pack
        if (g >= 4 - N) begin : g_byte
            assign payload[31 - 8*g -: 8] = n_hex_store[N - 4 + g];
        end else begin : g_zero
            assign payload[31 - 8*g -: 8] = 8'd0;
        end
    end

    assign o_mem_waddr = AW'(r_text_pos);
    assign o_mem_wdata = i_rx_byte;
    assign o_mem_raddr = AW'(i_read_index);

    always_comb begin
        o_res.status      = status;
        o_res.data_byte   = data_byte;
        o_res.use_mem     = use_mem;
        o_res.hex_payload = payload;
        o_res.text_length = 7'(n_text_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_mode     <= M_SINGLE;
            r_pending  <= 1'b0;
            r_last     <= 8'd0;
            r_hex_pos  <= '0;
            r_text_pos <= '0;
            r_hdr      <= HEX_HEADER_RST;
            r_trl      <= HEX_TRAILER_RST;
            for (int i = 0; i < N; i++) begin
                r_hex_store[i] <= 8'd0;
            end
        end else begin
            r_phase     <= n_phase;
            r_mode      <= n_mode;
            r_pending   <= n_pending;
            r_last      <= n_last;
            r_hex_pos   <= n_hex_pos;
            r_hex_store <= n_hex_store;
            r_text_pos  <= n_text_pos;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEX_HEADER:  r_hdr <= i_cfg_wdata;
                    CFG_HEX_TRAILER: r_trl <= i_cfg_wdata;
                    default:         r_hdr <= r_hdr;
                endcase
            end
        end
    end

    `ASSERT_RST(a_phase_mode, i_clk, i_rst_n, (r_phase != PH_IDLE) |-> (r_mode == M_HEX_RX || r_mode == M_TEXT_RX))
    `ASSERT_RST(a_text_cap, i_clk, i_rst_n, r_text_pos <= TPW'(TEXT_CAP))
    `ASSERT_RST(a_hex_pos, i_clk, i_rst_n, (r_phase == PH_BODY && r_mode == M_HEX_RX) |-> r_hex_pos < HPW'(N))
endmodule

### sv/htpr_out_stage.sv
// Read-data stage and output register; merges text store read data.
// Depends on htpr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module htpr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  htpr_pkg::t_result i_res,
    input  logic [7:0]        i_mem_rdata,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [7:0]        o_data_byte,
    output logic [31:0]       o_hex_payload,
    output logic [6:0]        o_text_length
);
    import htpr_pkg::*;

    logic        r_s1_valid;
    t_result     r_s1;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [7:0]  r_data_byte;
    logic [31:0] r_hex_payload;
    logic [6:0]  r_text_length;
    logic        s1_move;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_res;
        end
        if (s1_move) begin
            r_status      <= r_s1.status;
            r_data_byte   <= r_s1.use_mem ? i_mem_rdata : r_s1.data_byte;
            r_hex_payload <= r_s1.hex_payload;
            r_text_length <= r_s1.text_length;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_data_byte   = r_data_byte;
    assign o_hex_payload = r_hex_payload;
    assign o_text_length = r_text_length;

    `ASSERT_RST(a_stall_full, i_clk, i_rst_n, !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
    `ASSERT_RST(a_move_fills, i_clk, i_rst_n, s1_move |=> r_out_valid)
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_status) && $stable(r_data_byte) && $stable(r_hex_payload)))
endmodule

### sv/hex_and_text_packet_receiver.sv
// Hex and text packet receiver: takes one transaction per cycle unless stalled; one result each.
// Path: combinational parse into the read-data register (text read), then the output register.
// Throughput: one transaction per cycle unless the output stalls; one more transaction is
// taken while a result waits. State is read-modify-write and the text store read is registered.
// Reset: synchronous active-low reset clears control state and the hex payload; the text store
// is not cleared, reads at or past the text length return zero.
module hex_and_text_packet_receiver #(
    parameter int HEX_PAYLOAD_BYTES = htpr_pkg::HEX_PAYLOAD_BYTES_DEF,
    parameter int TEXT_DEPTH        = htpr_pkg::TEXT_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [htpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_wdata,
    htpr_in_if.sink                        i_rx_ch,
    htpr_out_if.source                     o_res_ch
);
    import htpr_pkg::*;

    localparam int AW = $clog2(TEXT_DEPTH);

    logic          accept;
    logic          in_ready;
    t_result       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    assign accept        = i_rx_ch.valid && in_ready;
    assign i_rx_ch.ready = in_ready;

    htpr_parse #(
        .HEX_PAYLOAD_BYTES(HEX_PAYLOAD_BYTES),
        .TEXT_DEPTH       (TEXT_DEPTH)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_kind      (i_rx_ch.kind),
        .i_rx_byte   (i_rx_ch.rx_byte),
        .i_read_index(i_rx_ch.read_index),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr)
    );

    htpr_text_mem #(
        .DEPTH(TEXT_DEPTH)
    ) u_text_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    htpr_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_res        (res),
        .i_mem_rdata  (mem_rdata),
        .i_out_ready  (o_res_ch.ready),
        .o_in_ready   (in_ready),
        .o_out_valid  (o_res_ch.valid),
        .o_status     (o_res_ch.status),
        .o_data_byte  (o_res_ch.data_byte),
        .o_hex_payload(o_res_ch.hex_payload),
        .o_text_length(o_res_ch.text_length)
    );
endmodule
